// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/fdl_pkg.sv =====
// ----------------------------------------------------------------------------
// fdl_pkg
// Types, codes and classification functions of the fault event logger.
// ----------------------------------------------------------------------------
package fdl_pkg;

    localparam int HISTORY_DEPTH_DEF = 8;
    localparam int READ_EXT_W        = 9;

    localparam logic [31:0] DEBOUNCE_RESET = 32'd2000;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [3:0] TOPIC_SYS_FAULT = 4'd0;
    localparam logic [3:0] TOPIC_SECURITY  = 4'd1;
    localparam logic [3:0] TOPIC_POWER     = 4'd2;
    localparam logic [3:0] TOPIC_NETWORK   = 4'd3;
    localparam logic [3:0] TOPIC_THRESHOLD = 4'd4;
    localparam logic [3:0] TOPIC_NONE      = 4'd15;

    typedef enum logic [1:0] {
        SEV_INFO,
        SEV_WARNING,
        SEV_ERROR,
        SEV_CRITICAL
    } sev_t;

    typedef enum logic [1:0] {
        DEV_BOOTING,
        DEV_NORMAL,
        DEV_DEGRADED,
        DEV_FAULT
    } dev_state_t;

    typedef struct packed {
        logic        en;
        logic [31:0] tick;
        logic [3:0]  topic;
        logic [7:0]  code;
        sev_t        sev;
    } hist_wr_t;

    typedef struct packed {
        logic       take;
        logic       read;
        logic [2:0] index;
    } hist_rd_t;

    typedef struct packed {
        logic [31:0] tick;
        logic [3:0]  topic;
        logic [7:0]  code;
        sev_t        sev;
    } hist_rec_t;

    typedef struct packed {
        logic       accepted;
        sev_t       sev;
        dev_state_t dev;
    } core_res_t;

    function automatic sev_t severity_of(logic [3:0] topic, logic [7:0] code);
        sev_t sev;
        case (topic) inside
            TOPIC_SYS_FAULT: sev = SEV_CRITICAL;
            TOPIC_SECURITY:  sev = SEV_ERROR;
            TOPIC_POWER, TOPIC_NETWORK, TOPIC_THRESHOLD:
                sev = (code != 8'd0) ? SEV_WARNING : SEV_INFO;
            default:         sev = SEV_INFO;
        endcase
        return sev;
    endfunction

    function automatic dev_state_t state_of(sev_t sev);
        dev_state_t st;
        case (sev)
            SEV_CRITICAL, SEV_ERROR: st = DEV_FAULT;
            SEV_WARNING:             st = DEV_DEGRADED;
            default:                 st = DEV_NORMAL;
        endcase
        return st;
    endfunction

endpackage

// ===== sv/fault_event_debounce_logger.sv =====
// ----------------------------------------------------------------------------
// fault_event_debounce_logger
// Severity classification, debounce and ring history of fault events.
// ----------------------------------------------------------------------------
// One transaction enters per clock cycle while in_ready is high. Each goes
// through an input register and then a result register that drives the
// outputs; a result that waits on out_ready holds the input register, which
// then takes a new transaction in the cycle the result leaves. The single
// memory write or read of the history and the 32-bit debounce compare sit
// between those registers. History entries carry valid bits that reset
// clears at once, so the block takes transactions right after reset.
module fault_event_debounce_logger
    import fdl_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [3:0]  event_topic,
    input  logic [7:0]  event_code,
    input  logic [31:0] now_tick,
    input  logic [2:0]  read_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [1:0]  device_state,
    output logic [1:0]  event_severity,
    output logic [31:0] record_tick,
    output logic [3:0]  record_topic,
    output logic [7:0]  record_code,
    output logic [1:0]  record_severity
);

`include "assert_macros.svh"

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_command_reg;
    logic [3:0]  s1_topic_reg;
    logic [7:0]  s1_code_reg;
    logic [31:0] s1_tick_reg;
    logic [2:0]  s1_index_reg;
    logic        out_valid_reg, out_valid_next;

    logic        s2_ready;
    logic        advance;
    hist_wr_t    wr;
    hist_rd_t    rd;
    hist_rec_t   rec;
    core_res_t   res;

    always_comb
    begin
        s2_ready      = !out_valid_reg || out_ready;
        advance       = s1_valid_reg && s2_ready;
        in_ready      = !s1_valid_reg || s2_ready;
        s1_valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        rd.take  = advance;
        rd.read  = s1_command_reg == CMD_READ;
        rd.index = s1_index_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the transaction while the result side stalls
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_command_reg <= command;
            s1_topic_reg   <= event_topic;
            s1_code_reg    <= event_code;
            s1_tick_reg    <= now_tick;
            s1_index_reg   <= read_index;
        end
    end

    fdl_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .advance     (advance),
        .command     (s1_command_reg),
        .event_topic (s1_topic_reg),
        .event_code  (s1_code_reg),
        .now_tick    (s1_tick_reg),
        .wr          (wr),
        .res         (res)
    );

    fdl_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .rec   (rec)
    );

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign accepted        = res.accepted;
    assign device_state    = res.dev;
    assign event_severity  = res.sev;
    assign record_tick     = rec.tick;
    assign record_topic    = rec.topic;
    assign record_code     = rec.code;
    assign record_severity = rec.sev;

    `ASSERT_NEXT(a_advance_gives_result, advance, out_valid, "advance did not produce a result")
    `ASSERT_SAME(a_debounce_no_record, out_valid && !accepted, (record_tick == 32'd0) && (record_topic == 4'd0) && (record_code == 8'd0), "debounced result carries a record")
    `ASSERT_SAME(a_severity_state, out_valid && accepted && (event_severity != SEV_INFO), (device_state == DEV_FAULT) || (device_state == DEV_DEGRADED), "accepted non-info event left wrong device state")

endmodule

// ===== sv/fdl_core.sv =====
// ----------------------------------------------------------------------------
// fdl_core
// Debounce compare, device state and result register for event transactions.
// ----------------------------------------------------------------------------
module fdl_core
    import fdl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  logic        advance,
    input  logic        command,
    input  logic [3:0]  event_topic,
    input  logic [7:0]  event_code,
    input  logic [31:0] now_tick,
    output hist_wr_t    wr,
    output core_res_t   res
);

    logic [31:0] window_reg;
    dev_state_t  dev_reg, dev_next;
    logic [3:0]  last_topic_reg, last_topic_next;
    logic [7:0]  last_code_reg, last_code_next;
    logic [31:0] last_tick_reg, last_tick_next;
    core_res_t   res_reg, res_next;

    sev_t        sev;
    logic [31:0] elapsed;
    logic        repeated;
    logic        take_event;

    always_comb
    begin
        sev        = severity_of(event_topic, event_code);
        elapsed    = now_tick - last_tick_reg;
        repeated   = (event_topic == last_topic_reg) && (event_code == last_code_reg) &&
                     (elapsed < window_reg);
        take_event = advance && (command == CMD_EVENT) && !repeated;

        dev_next        = dev_reg;
        last_topic_next = last_topic_reg;
        last_code_next  = last_code_reg;
        last_tick_next  = last_tick_reg;
        if (take_event)
        begin
            dev_next        = state_of(sev);
            last_topic_next = event_topic;
            last_code_next  = event_code;
            last_tick_next  = now_tick;
        end

        res_next = res_reg;
        if (advance)
        begin
            res_next.dev = dev_next;
            if (command == CMD_READ)
            begin
                res_next.accepted = 1'b1;
                res_next.sev      = SEV_INFO;
            end
            else
            begin
                res_next.accepted = !repeated;
                res_next.sev      = sev;
            end
        end

        wr.en    = take_event && (sev != SEV_INFO);
        wr.tick  = now_tick;
        wr.topic = event_topic;
        wr.code  = event_code;
        wr.sev   = sev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= DEBOUNCE_RESET;
            dev_reg        <= DEV_BOOTING;
            last_topic_reg <= TOPIC_NONE;
            last_code_reg  <= 8'd0;
            last_tick_reg  <= 32'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                window_reg <= cfg_data;
            end
            dev_reg        <= dev_next;
            last_topic_reg <= last_topic_next;
            last_code_reg  <= last_code_next;
            last_tick_reg  <= last_tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== sv/fdl_history.sv =====
// ----------------------------------------------------------------------------
// fdl_history
// Ring history memory with per-entry valid bits and registered read record.
// ----------------------------------------------------------------------------
module fdl_history
    import fdl_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  hist_wr_t  wr,
    input  hist_rd_t  rd,
    output hist_rec_t rec
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);

    hist_rec_t                mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [IDX_W-1:0]         slot_reg, slot_next;
    hist_rec_t                data_reg;
    logic                     hit_reg;

    logic [READ_EXT_W-1:0]    rd_ext;
    logic                     rd_in_range;
    logic [IDX_W-1:0]         rd_addr;

    always_comb
    begin
        rd_ext      = READ_EXT_W'(rd.index);
        rd_in_range = rd_ext < READ_EXT_W'(HISTORY_DEPTH);
        rd_addr     = rd_ext[IDX_W-1:0];
        slot_next   = slot_reg;
        if (wr.en)
        begin
            slot_next = (slot_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            if (wr.en)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            if (rd.take)
            begin
                hit_reg <= rd.read && rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[slot_reg] <= '{tick: wr.tick, topic: wr.topic, code: wr.code, sev: wr.sev};
        end
        if (rd.take && rd.read && rd_in_range)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rec = hit_reg ? data_reg : '0;

endmodule

// ===== tb/tb_fault_event_debounce_logger.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fault_event_debounce_logger
// Self-checking bench for the fault event debounce logger. Every command sent
// is run through a local model of severity, debounce, device state and the
// ring history, and each returned transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_fault_event_debounce_logger;
    import fdl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       accepted;
        dev_state_t dev_state;
        sev_t       severity;
        hist_rec_t  record;
    } log_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_EVENT;
    logic [3:0]  event_topic = '0;
    logic [7:0]  event_code = '0;
    logic [31:0] now_tick = '0;
    logic [2:0]  read_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        accepted;
    logic [1:0]  device_state;
    logic [1:0]  event_severity;
    logic [31:0] record_tick;
    logic [3:0]  record_topic;
    logic [7:0]  record_code;
    logic [1:0]  record_severity;

    log_result_t expected_log[$];

    logic [31:0] model_window = DEBOUNCE_RESET;
    dev_state_t  model_dev = DEV_BOOTING;
    logic [3:0]  model_last_topic = TOPIC_NONE;
    logic [7:0]  model_last_code = '0;
    logic [31:0] model_last_tick = '0;
    logic [2:0]  model_slot = '0;
    hist_rec_t   log_history [8];

    logic [31:0] tick_base = '0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int commands_sent = 0;
    int debounced_seen = 0;
    int reads_seen = 0;
    int windows_used = 0;

    fault_event_debounce_logger DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .event_topic     (event_topic),
        .event_code      (event_code),
        .now_tick        (now_tick),
        .read_index      (read_index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .accepted        (accepted),
        .device_state    (device_state),
        .event_severity  (event_severity),
        .record_tick     (record_tick),
        .record_topic    (record_topic),
        .record_code     (record_code),
        .record_severity (record_severity)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            log_history[i] = '0;
        end
    end

    function automatic sev_t classify_event(logic [3:0] topic, logic [7:0] code);
        if (topic == TOPIC_SYS_FAULT)
            return SEV_CRITICAL;
        if (topic == TOPIC_SECURITY)
            return SEV_ERROR;
        if (topic >= TOPIC_POWER && topic <= TOPIC_THRESHOLD)
            return (code != 8'd0) ? SEV_WARNING : SEV_INFO;
        return SEV_INFO;
    endfunction

    function automatic log_result_t predict_log_result(logic cmd, logic [3:0] topic,
                                                       logic [7:0] code, logic [31:0] tick,
                                                       logic [2:0] index);
        log_result_t r;
        sev_t        sev;
        logic [31:0] elapsed;
        r = '0;
        if (cmd == CMD_READ)
        begin
            r.accepted = 1'b1;
            r.record = log_history[index];
            reads_seen++;
        end
        else
        begin
            sev = classify_event(topic, code);
            elapsed = tick - model_last_tick;
            r.severity = sev;
            if (topic == model_last_topic && code == model_last_code && elapsed < model_window)
            begin
                r.accepted = 1'b0;
                debounced_seen++;
            end
            else
            begin
                r.accepted = 1'b1;
                model_last_topic = topic;
                model_last_code = code;
                model_last_tick = tick;
                case (sev)
                    SEV_CRITICAL, SEV_ERROR: model_dev = DEV_FAULT;
                    SEV_WARNING:             model_dev = DEV_DEGRADED;
                    default:                 model_dev = DEV_NORMAL;
                endcase
                if (sev != SEV_INFO)
                begin
                    log_history[model_slot].tick = tick;
                    log_history[model_slot].topic = topic;
                    log_history[model_slot].code = code;
                    log_history[model_slot].sev = sev;
                    model_slot = model_slot + 3'd1;
                end
            end
        end
        r.dev_state = model_dev;
        return r;
    endfunction

    task automatic issue_command(input logic cmd, input logic [3:0] topic,
                                 input logic [7:0] code, input logic [31:0] tick,
                                 input logic [2:0] index);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        event_topic <= topic;
        event_code  <= code;
        now_tick    <= tick;
        read_index  <= index;
        do
            @(posedge clk);
        while (!in_ready);
        expected_log.push_back(predict_log_result(cmd, topic, code, tick, index));
        commands_sent++;
    endtask

    task automatic send_event(input logic [3:0] topic, input logic [7:0] code,
                              input logic [31:0] tick);
        issue_command(CMD_EVENT, topic, code, tick, 3'($urandom_range(0, 7)));
    endtask

    task automatic send_read(input logic [2:0] index);
        issue_command(CMD_READ, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      $urandom(), index);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_log.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_window(input logic [31:0] value);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_window = value;
        windows_used++;
        @(posedge clk);
    endtask

    task automatic send_random_events(input int count, input int step_max);
        logic [3:0] topic;
        logic [7:0] code;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_read(3'($urandom_range(0, 7)));
            end
            else
            begin
                if ($urandom_range(99) < 40)
                begin
                    topic = model_last_topic;
                    code = model_last_code;
                end
                else
                begin
                    topic = ($urandom_range(99) < 80) ? 4'($urandom_range(0, 4))
                                                      : 4'($urandom_range(5, 15));
                    code = ($urandom_range(99) < 20) ? 8'd0 : 8'($urandom_range(0, 255));
                end
                if ($urandom_range(99) < 4)
                    tick_base = $urandom();
                else
                    tick_base = tick_base + $urandom_range(0, step_max);
                send_event(topic, code, tick_base);
            end
        end
    endtask

    task automatic test_reset_state();
        send_read(3'd0);
        send_read(3'd7);
        send_event(TOPIC_NONE, 8'd0, 32'd5);
        send_event(TOPIC_NONE, 8'd0, 32'd2000);
    endtask

    task automatic test_severity_classes();
        send_event(TOPIC_SYS_FAULT, 8'h00, 32'hFFFF_FFFF);
        send_event(TOPIC_SECURITY, 8'hFF, 32'h0000_0010);
        send_event(TOPIC_POWER, 8'h00, 32'h0000_0020);
        send_event(TOPIC_POWER, 8'h01, 32'h0000_0030);
        send_event(TOPIC_NETWORK, 8'h80, 32'h8000_0000);
        send_event(TOPIC_THRESHOLD, 8'h55, 32'h5555_5555);
        send_event(TOPIC_THRESHOLD, 8'h00, 32'hAAAA_AAAA);
        send_event(4'd5, 8'hAA, 32'h0000_0100);
        send_event(4'd14, 8'hFF, 32'h0000_0200);
    endtask

    task automatic test_debounce_edges();
        send_event(TOPIC_SYS_FAULT, 8'd7, 32'd100);
        send_event(TOPIC_SYS_FAULT, 8'd7, 32'd2099);
        send_event(TOPIC_SYS_FAULT, 8'd7, 32'd2100);
        send_event(TOPIC_SECURITY, 8'd3, 32'hFFFF_FF00);
        send_event(TOPIC_SECURITY, 8'd3, 32'h0000_0100);
        send_read(3'd0);
        send_read(3'd3);
        send_read(3'd7);
    endtask

    task automatic test_window_extremes();
        write_window(32'd0);
        send_event(TOPIC_POWER, 8'd9, 32'd500);
        send_event(TOPIC_POWER, 8'd9, 32'd500);
        write_window(32'hFFFF_FFFF);
        send_event(TOPIC_POWER, 8'd9, 32'd600);
        send_event(TOPIC_POWER, 8'd9, 32'd499);
        write_window(32'd1);
        send_event(TOPIC_POWER, 8'd9, 32'd499);
        send_event(TOPIC_POWER, 8'd9, 32'd500);
        write_window(DEBOUNCE_RESET);
    endtask

    task automatic test_random_traffic(input int count, input logic [31:0] window,
                                       input int step_max);
        write_window(window);
        send_random_events(count, step_max);
    endtask

    task automatic test_backpressure();
        wait_results_drained();
        hold_req = 300;
        send_random_events(60, 700);
        wait_results_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_left == 0 && hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        log_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_log.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: acc=%0b dev=%0d sev=%0d", accepted,
                             device_state, event_severity);
            end
            else
            begin
                want = expected_log.pop_front();
                if (accepted !== want.accepted || device_state !== want.dev_state ||
                    event_severity !== want.severity || record_tick !== want.record.tick ||
                    record_topic !== want.record.topic || record_code !== want.record.code ||
                    record_severity !== want.record.sev)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp: acc=%0b dev=%0d sev=%0d rec=%h/%h/%h/%0d",
                                 want.accepted, want.dev_state, want.severity,
                                 want.record.tick, want.record.topic, want.record.code,
                                 want.record.sev);
                        $display("         got: acc=%0b dev=%0d sev=%0d rec=%h/%h/%h/%0d",
                                 accepted, device_state, event_severity, record_tick,
                                 record_topic, record_code, record_severity);
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_severity_classes();
        test_debounce_edges();
        test_window_extremes();

        send_idle_pct = 20;
        recv_idle_pct = 48;
        test_random_traffic(650, 32'd64, 24);

        send_idle_pct = 48;
        recv_idle_pct = 20;
        test_random_traffic(650, 32'd1500, 500);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_traffic(590, DEBOUNCE_RESET, 700);

        wait_results_drained();
        repeat (8) @(posedge clk);

        $display("Ran %0d commands: %0d debounced events, %0d history reads, %0d windows",
                 commands_sent, debounced_seen, reads_seen, windows_used);
        $display("Mismatching transactions: %0d", mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== fault_event_debounce_logger.f =====
+incdir+sv
sv/fdl_pkg.sv
sv/fdl_core.sv
sv/fdl_history.sv
sv/fault_event_debounce_logger.sv
tb/tb_fault_event_debounce_logger.sv
